FILE: rtl/tftpss_pkg.sv
package tftpss_pkg;

	// received packet opcodes
	localparam logic [15:0] OP_RRQ   = 16'd1;
	localparam logic [15:0] OP_WRQ   = 16'd2;
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ACK   = 16'd4;
	localparam logic [15:0] OP_ERROR = 16'd5;

	// reply packet opcodes
	localparam logic [2:0] RP_NONE  = 3'd0;
	localparam logic [2:0] RP_DATA  = 3'd3;
	localparam logic [2:0] RP_ACK   = 3'd4;
	localparam logic [2:0] RP_ERROR = 3'd5;

	localparam logic [10:0] MIN_REQUEST_BYTES = 11'd6;
	localparam int HDR_BYTES = 4;

	// error message indexes
	localparam logic [3:0] MSG_OPCODE    = 4'd0;
	localparam logic [3:0] MSG_BUSY      = 4'd1;
	localparam logic [3:0] MSG_SHORT     = 4'd2;
	localparam logic [3:0] MSG_MODE      = 4'd3;
	localparam logic [3:0] MSG_TRAVERSAL = 4'd4;
	localparam logic [3:0] MSG_STAT      = 4'd5;
	localparam logic [3:0] MSG_PERMS     = 4'd6;
	localparam logic [3:0] MSG_ORDER     = 4'd7;
	localparam logic [3:0] MSG_SIZE      = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_WRITE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE       = 2'd0,
		ACT_SEND       = 2'd1,
		ACT_SEND_RESET = 2'd2,
		ACT_RESET      = 2'd3
	} action_t;

	typedef struct packed {
		logic        timed_out;
		logic [15:0] opcode_word;
		logic [15:0] second_word;
		logic [10:0] packet_length;
		logic        mode_octet;
		logic        name_safe;
		logic        file_present;
		logic        file_readable;
		logic [9:0]  file_bytes;
	} pkt_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  reply_opcode;
		logic [15:0] reply_word;
		logic [9:0]  reply_length;
		logic [3:0]  message_id;
		logic        store_payload;
	} rsp_t;

	// header of the last packet prepared
	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] word;
		logic [9:0]  length;
		logic [3:0]  message;
	} hdr_t;

	// error code carried in the error packet
	function automatic logic [15:0] msg_code(input logic [3:0] id);
		logic [15:0] c;
		case (id)
			MSG_BUSY:      c = 16'd5;
			MSG_TRAVERSAL: c = 16'd2;
			MSG_STAT:      c = 16'd2;
			MSG_PERMS:     c = 16'd2;
			MSG_ORDER:     c = 16'd4;
			default:       c = 16'd0;
		endcase
		return c;
	endfunction

	// message text length without terminator
	function automatic logic [9:0] msg_len(input logic [3:0] id);
		logic [9:0] n;
		case (id)
			MSG_OPCODE:    n = 10'd14;
			MSG_BUSY:      n = 10'd27;
			MSG_SHORT:     n = 10'd17;
			MSG_TRAVERSAL: n = 10'd15;
			MSG_STAT:      n = 10'd19;
			default:       n = 10'd20;
		endcase
		return n;
	endfunction

	function automatic hdr_t make_error(input logic [3:0] id);
		hdr_t h;
		h.opcode  = RP_ERROR;
		h.word    = msg_code(id);
		h.length  = msg_len(id) + 10'd5;
		h.message = id;
		return h;
	endfunction

endpackage

FILE: rtl/tftpss_if.sv
interface tftpss_pkt_if;
	logic               valid;
	logic               ready;
	tftpss_pkg::pkt_t   item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface tftpss_rsp_if;
	logic               valid;
	logic               ready;
	tftpss_pkg::rsp_t   item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

FILE: rtl/tftpss_core.sv
module tftpss_core #(
	parameter int BLOCK_BYTES = 512,
	parameter int RECV_BYTES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  tftpss_pkg::pkt_t  item,
	output tftpss_pkg::rsp_t  result
);
	localparam int SUM_W = $clog2(RECV_BYTES + BLOCK_BYTES + 8);
	localparam int CW = (SUM_W > 11) ? SUM_W : 11;

	tftpss_pkg::status_t status_q, nxt_status;
	logic [15:0]         block_q, nxt_block;
	tftpss_pkg::hdr_t    last_q, nxt_last;
	tftpss_pkg::action_t act;
	logic                store;
	logic [CW-1:0]       len_w, fb_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= tftpss_pkg::ST_IDLE;
			block_q  <= '0;
			last_q   <= '0;
		end else if (advance) begin
			status_q <= nxt_status;
			block_q  <= nxt_block;
			last_q   <= nxt_last;
		end
	end

	always_comb begin
		// saturate the counts
		len_w = (CW'(item.packet_length) > CW'(RECV_BYTES)) ? CW'(RECV_BYTES)
			: CW'(item.packet_length);
		fb_w = (CW'(item.file_bytes) > CW'(BLOCK_BYTES)) ? CW'(BLOCK_BYTES)
			: CW'(item.file_bytes);

		nxt_status = status_q;
		nxt_block  = block_q;
		nxt_last   = last_q;
		act        = tftpss_pkg::ACT_NONE;
		store      = 1'b0;

		if (item.timed_out) begin
			act = (status_q != tftpss_pkg::ST_IDLE) ? tftpss_pkg::ACT_SEND
				: tftpss_pkg::ACT_NONE;
		end else if (item.opcode_word < tftpss_pkg::OP_RRQ
				|| item.opcode_word > tftpss_pkg::OP_ERROR) begin
			nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_OPCODE);
			act      = tftpss_pkg::ACT_SEND_RESET;
		end else if (item.opcode_word == tftpss_pkg::OP_RRQ
				|| item.opcode_word == tftpss_pkg::OP_WRQ) begin
			act = tftpss_pkg::ACT_SEND_RESET;
			if (status_q != tftpss_pkg::ST_IDLE) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_BUSY);
				act      = tftpss_pkg::ACT_SEND;
			end else if (len_w < CW'(tftpss_pkg::MIN_REQUEST_BYTES)) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_SHORT);
			end else if (!item.mode_octet) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_MODE);
			end else if (!item.name_safe) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_TRAVERSAL);
			end else if (item.opcode_word == tftpss_pkg::OP_RRQ && !item.file_present) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_STAT);
			end else if (item.opcode_word == tftpss_pkg::OP_RRQ && !item.file_readable) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_PERMS);
			end else if (item.opcode_word == tftpss_pkg::OP_RRQ) begin
				// read session opens with data block one
				nxt_status      = tftpss_pkg::ST_READ;
				nxt_block       = 16'd1;
				nxt_last.opcode  = tftpss_pkg::RP_DATA;
				nxt_last.word    = 16'd1;
				nxt_last.length  = 10'(CW'(tftpss_pkg::HDR_BYTES) + fb_w);
				nxt_last.message = '0;
				act = (fb_w < CW'(BLOCK_BYTES)) ? tftpss_pkg::ACT_SEND_RESET
					: tftpss_pkg::ACT_SEND;
			end else begin
				nxt_status      = tftpss_pkg::ST_WRITE;
				nxt_block       = 16'd0;
				nxt_last.opcode  = tftpss_pkg::RP_ACK;
				nxt_last.word    = 16'd0;
				nxt_last.length  = 10'(tftpss_pkg::HDR_BYTES);
				nxt_last.message = '0;
				act = tftpss_pkg::ACT_SEND;
			end
		end else if (item.opcode_word == tftpss_pkg::OP_DATA) begin
			if (status_q != tftpss_pkg::ST_WRITE) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_ORDER);
				act      = tftpss_pkg::ACT_SEND_RESET;
			end else if (len_w > CW'(tftpss_pkg::HDR_BYTES + BLOCK_BYTES)
					|| len_w < CW'(tftpss_pkg::HDR_BYTES)) begin
				nxt_last = tftpss_pkg::make_error(tftpss_pkg::MSG_SIZE);
				act      = tftpss_pkg::ACT_SEND_RESET;
			end else if (item.second_word <= block_q) begin
				act = tftpss_pkg::ACT_NONE;
			end else begin
				store            = 1'b1;
				nxt_block        = block_q + 16'd1;
				nxt_last.opcode  = tftpss_pkg::RP_ACK;
				nxt_last.word    = block_q + 16'd1;
				nxt_last.length  = 10'(tftpss_pkg::HDR_BYTES);
				nxt_last.message = '0;
				act = (len_w < CW'(tftpss_pkg::HDR_BYTES + BLOCK_BYTES))
					? tftpss_pkg::ACT_SEND_RESET : tftpss_pkg::ACT_SEND;
			end
		end else if (item.opcode_word == tftpss_pkg::OP_ACK) begin
			if (status_q == tftpss_pkg::ST_READ && item.second_word == block_q) begin
				nxt_block        = block_q + 16'd1;
				nxt_last.opcode  = tftpss_pkg::RP_DATA;
				nxt_last.word    = block_q + 16'd1;
				nxt_last.length  = 10'(CW'(tftpss_pkg::HDR_BYTES) + fb_w);
				nxt_last.message = '0;
				act = (fb_w < CW'(BLOCK_BYTES)) ? tftpss_pkg::ACT_SEND_RESET
					: tftpss_pkg::ACT_SEND;
			end
		end else begin
			act = tftpss_pkg::ACT_RESET;
		end

		// session ends on a reset action, after the reply if one is sent
		if (act == tftpss_pkg::ACT_SEND_RESET || act == tftpss_pkg::ACT_RESET) begin
			nxt_status = tftpss_pkg::ST_IDLE;
			nxt_block  = '0;
		end

		result.action        = act;
		result.store_payload = store;
		if (act == tftpss_pkg::ACT_SEND || act == tftpss_pkg::ACT_SEND_RESET) begin
			result.reply_opcode = nxt_last.opcode;
			result.reply_word   = nxt_last.word;
			result.reply_length = nxt_last.length;
			result.message_id   = nxt_last.message;
		end else begin
			result.reply_opcode = tftpss_pkg::RP_NONE;
			result.reply_word   = '0;
			result.reply_length = '0;
			result.message_id   = '0;
		end
	end
endmodule

FILE: rtl/tftp_server_session_step.sv
// channel | dir | transaction contents
// pkt     | in  | one received-packet event (timeout flag, opcode, word, length, check flags)
// rsp     | out | one reply decision (action, reply header, message index, store flag)
//
// one event accepted every cycle unless a stalled rsp fills both stages; each event passes
// the input stage, the core and the result stage; the core's session state loop sets that rate
// reset clears the session to idle, block number zero and the saved header to zero
// a stalled rsp holds its reply; pkt keeps flowing until the input stage also fills
module tftp_server_session_step #(
	parameter int BLOCK_BYTES = 512,
	parameter int RECV_BYTES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	tftpss_pkt_if.sink   pkt,
	tftpss_rsp_if.source rsp
);
	// input stage
	logic             valid_s1;
	tftpss_pkg::pkt_t pkt_s1;
	// result stage
	logic             valid_s2;
	tftpss_pkg::rsp_t rsp_s2;

	tftpss_pkg::rsp_t result;
	logic             advance;

	// the input stage moves on when the result stage is free or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign pkt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			pkt_s1 <= pkt.item;
		end
	end

	// decision logic plus session state, updated once per event
	tftpss_core #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.RECV_BYTES(RECV_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(pkt_s1),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.item  = rsp_s2;
endmodule

FILE: rtl/tftpss_check.sv
module tftpss_check (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input tftpss_pkg::rsp_t rsp_item
);
	// quiet replies carry no header
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_item.action == tftpss_pkg::ACT_NONE
			|| rsp_item.action == tftpss_pkg::ACT_RESET)
		|-> rsp_item.reply_opcode == tftpss_pkg::RP_NONE && rsp_item.reply_word == 16'd0
			&& rsp_item.reply_length == 10'd0 && rsp_item.message_id == 4'd0)
		else $error("quiet reply with header");

	// a sent reply is data, ack or error
	a_send_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_item.action == tftpss_pkg::ACT_SEND
			|| rsp_item.action == tftpss_pkg::ACT_SEND_RESET)
		|-> rsp_item.reply_opcode == tftpss_pkg::RP_DATA
			|| rsp_item.reply_opcode == tftpss_pkg::RP_ACK
			|| rsp_item.reply_opcode == tftpss_pkg::RP_ERROR)
		else $error("sent reply with bad opcode");

	// stored payload is always acknowledged
	a_store_ack: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.store_payload
		|-> rsp_item.reply_opcode == tftpss_pkg::RP_ACK && rsp_item.reply_length == 10'd4)
		else $error("stored payload without ack");

	// a stalled reply holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("stalled reply changed");
endmodule

bind tftp_server_session_step tftpss_check u_check (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_item(rsp.item)
);

FILE: tb/tb_tftp_server_session_step.sv
module tb_tftp_server_session_step;

	localparam int BLOCK_BYTES = 512;
	localparam int RECV_BYTES = 1024;
	// full data packet: header plus one whole block
	localparam int FULL_PACKET = tftpss_pkg::HDR_BYTES + BLOCK_BYTES;
	// cycles with no transaction on either channel before the run is called hung
	localparam int QUIET_LIMIT = 2000;
	// each reply passes the input and result stages, leave some margin after the last one
	localparam int TAIL_CYCLES = 8;
	// length of the deliberate receiver hold-off
	localparam int HOLD_CYCLES = 80;

	// error codes carried in the error packet header
	localparam logic [15:0] ERRC_UNDEF   = 16'd0;
	localparam logic [15:0] ERRC_ACCESS  = 16'd2;
	localparam logic [15:0] ERRC_ILLEGAL = 16'd4;
	localparam logic [15:0] ERRC_TID     = 16'd5;

	// check flag patterns {mode_octet, name_safe, file_present, file_readable}
	localparam logic [3:0] CHECKS_OK = 4'b1111;

	logic clk = 1'b0;
	logic arst_n;

	tftpss_pkt_if pkt_ch();
	tftpss_rsp_if rsp_ch();

	tftp_server_session_step #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.RECV_BYTES(RECV_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.rsp(rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the session kept by the checker
	tftpss_pkg::status_t sess_status;
	logic [15:0]         sess_block;
	tftpss_pkg::hdr_t    sent_hdr;

	// replies owed by the block, oldest first
	tftpss_pkg::rsp_t reply_q[$];

	bit gaps_on;          // random idle cycles on both channels
	int rsp_hold;         // pending receiver hold-off, in cycles
	int events_sent;
	int replies_checked;
	int mismatches;

	// ------------------------------------------------------------------
	// session model
	// ------------------------------------------------------------------

	// header of an error reply; length is text length plus header and terminator
	function automatic tftpss_pkg::hdr_t error_packet(input logic [3:0] id);
		tftpss_pkg::hdr_t h;
		h.opcode = tftpss_pkg::RP_ERROR;
		h.message = id;
		case (id) inside
			tftpss_pkg::MSG_BUSY: begin
				h.word = ERRC_TID;
				h.length = 10'd32;
			end
			tftpss_pkg::MSG_SHORT: begin
				h.word = ERRC_UNDEF;
				h.length = 10'd22;
			end
			tftpss_pkg::MSG_TRAVERSAL: begin
				h.word = ERRC_ACCESS;
				h.length = 10'd20;
			end
			tftpss_pkg::MSG_STAT: begin
				h.word = ERRC_ACCESS;
				h.length = 10'd24;
			end
			tftpss_pkg::MSG_PERMS: begin
				h.word = ERRC_ACCESS;
				h.length = 10'd25;
			end
			tftpss_pkg::MSG_ORDER: begin
				h.word = ERRC_ILLEGAL;
				h.length = 10'd25;
			end
			tftpss_pkg::MSG_MODE, tftpss_pkg::MSG_SIZE: begin
				h.word = ERRC_UNDEF;
				h.length = 10'd25;
			end
			default: begin
				// bad opcode
				h.word = ERRC_UNDEF;
				h.length = 10'd19;
			end
		endcase
		return h;
	endfunction

	// prepare a data block; a short block is the last one of the transfer
	function automatic tftpss_pkg::action_t load_data(input logic [9:0] nbytes);
		sent_hdr.opcode = tftpss_pkg::RP_DATA;
		sent_hdr.word = sess_block;
		sent_hdr.length = 10'(tftpss_pkg::HDR_BYTES) + nbytes;
		sent_hdr.message = '0;
		if (nbytes < 10'(BLOCK_BYTES))
			return tftpss_pkg::ACT_SEND_RESET;
		return tftpss_pkg::ACT_SEND;
	endfunction

	function automatic void load_ack();
		sent_hdr.opcode = tftpss_pkg::RP_ACK;
		sent_hdr.word = sess_block;
		sent_hdr.length = 10'(tftpss_pkg::HDR_BYTES);
		sent_hdr.message = '0;
	endfunction

	// advance the shadow session by one event and return the reply it owes
	function automatic tftpss_pkg::rsp_t next_reply(input tftpss_pkg::pkt_t p);
		logic [10:0]         rx_len;
		logic [9:0]          fb;
		tftpss_pkg::action_t act;
		logic                store;
		tftpss_pkg::rsp_t    r;
		// counts saturate at the buffer sizes
		rx_len = (p.packet_length > 11'(RECV_BYTES)) ? 11'(RECV_BYTES) : p.packet_length;
		fb = (p.file_bytes > 10'(BLOCK_BYTES)) ? 10'(BLOCK_BYTES) : p.file_bytes;
		act = tftpss_pkg::ACT_NONE;
		store = 1'b0;
		if (p.timed_out) begin
			// retransmit whatever went out last, unless there is no session
			if (sess_status != tftpss_pkg::ST_IDLE)
				act = tftpss_pkg::ACT_SEND;
		end else if (p.opcode_word < tftpss_pkg::OP_RRQ
				|| p.opcode_word > tftpss_pkg::OP_ERROR) begin
			sent_hdr = error_packet(tftpss_pkg::MSG_OPCODE);
			act = tftpss_pkg::ACT_SEND_RESET;
		end else if (p.opcode_word == tftpss_pkg::OP_RRQ
				|| p.opcode_word == tftpss_pkg::OP_WRQ) begin
			if (sess_status != tftpss_pkg::ST_IDLE) begin
				// busy: complain but keep the running session
				sent_hdr = error_packet(tftpss_pkg::MSG_BUSY);
				act = tftpss_pkg::ACT_SEND;
			end else if (rx_len < tftpss_pkg::MIN_REQUEST_BYTES) begin
				sent_hdr = error_packet(tftpss_pkg::MSG_SHORT);
				act = tftpss_pkg::ACT_SEND_RESET;
			end else if (!p.mode_octet) begin
				sent_hdr = error_packet(tftpss_pkg::MSG_MODE);
				act = tftpss_pkg::ACT_SEND_RESET;
			end else if (!p.name_safe) begin
				sent_hdr = error_packet(tftpss_pkg::MSG_TRAVERSAL);
				act = tftpss_pkg::ACT_SEND_RESET;
			end else if (p.opcode_word == tftpss_pkg::OP_WRQ) begin
				// write ignores the file flags and acks block zero
				sess_status = tftpss_pkg::ST_WRITE;
				sess_block = '0;
				load_ack();
				act = tftpss_pkg::ACT_SEND;
			end else if (!p.file_present) begin
				sent_hdr = error_packet(tftpss_pkg::MSG_STAT);
				act = tftpss_pkg::ACT_SEND_RESET;
			end else if (!p.file_readable) begin
				sent_hdr = error_packet(tftpss_pkg::MSG_PERMS);
				act = tftpss_pkg::ACT_SEND_RESET;
			end else begin
				sess_status = tftpss_pkg::ST_READ;
				sess_block = 16'd1;
				act = load_data(fb);
			end
		end else if (p.opcode_word == tftpss_pkg::OP_DATA) begin
			if (sess_status != tftpss_pkg::ST_WRITE) begin
				sent_hdr = error_packet(tftpss_pkg::MSG_ORDER);
				act = tftpss_pkg::ACT_SEND_RESET;
			end else if (rx_len > 11'(FULL_PACKET)
					|| rx_len < 11'(tftpss_pkg::HDR_BYTES)) begin
				sent_hdr = error_packet(tftpss_pkg::MSG_SIZE);
				act = tftpss_pkg::ACT_SEND_RESET;
			end else if (p.second_word > sess_block) begin
				// any block number ahead of the current one is taken as the next
				store = 1'b1;
				sess_block = sess_block + 16'd1;
				load_ack();
				act = (rx_len < 11'(FULL_PACKET)) ? tftpss_pkg::ACT_SEND_RESET
					: tftpss_pkg::ACT_SEND;
			end
		end else if (p.opcode_word == tftpss_pkg::OP_ACK) begin
			// acks outside a read session or for another block are dropped
			if (sess_status == tftpss_pkg::ST_READ && p.second_word == sess_block) begin
				sess_block = sess_block + 16'd1;
				act = load_data(fb);
			end
		end else begin
			// peer sent an error packet
			act = tftpss_pkg::ACT_RESET;
		end
		r = '0;
		r.action = act;
		if (act == tftpss_pkg::ACT_SEND || act == tftpss_pkg::ACT_SEND_RESET) begin
			r.reply_opcode = sent_hdr.opcode;
			r.reply_word = sent_hdr.word;
			r.reply_length = sent_hdr.length;
			r.message_id = sent_hdr.message;
		end
		r.store_payload = store;
		// saved header survives the session reset
		if (act == tftpss_pkg::ACT_SEND_RESET || act == tftpss_pkg::ACT_RESET) begin
			sess_status = tftpss_pkg::ST_IDLE;
			sess_block = '0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// event builders
	// ------------------------------------------------------------------

	// every field random, timeout flag included
	function automatic tftpss_pkg::pkt_t noise_pkt();
		tftpss_pkg::pkt_t p;
		p.timed_out = 1'($urandom);
		p.opcode_word = 16'($urandom);
		p.second_word = 16'($urandom);
		p.packet_length = 11'($urandom);
		{p.mode_octet, p.name_safe, p.file_present, p.file_readable} = 4'($urandom);
		p.file_bytes = 10'($urandom);
		return p;
	endfunction

	// a received packet with the timeout flag clear and every other field as given
	function automatic tftpss_pkg::pkt_t packet(input logic [15:0] op,
			input logic [15:0] word, input logic [10:0] len, input logic [3:0] checks,
			input logic [9:0] fbytes);
		tftpss_pkg::pkt_t p;
		p = noise_pkt();
		p.timed_out = 1'b0;
		p.opcode_word = op;
		p.second_word = word;
		p.packet_length = len;
		{p.mode_octet, p.name_safe, p.file_present, p.file_readable} = checks;
		p.file_bytes = fbytes;
		return p;
	endfunction

	function automatic tftpss_pkg::pkt_t timeout_pkt();
		tftpss_pkg::pkt_t p;
		p = noise_pkt();
		p.timed_out = 1'b1;
		return p;
	endfunction

	// bytes for the next data block: mostly full blocks so sessions run a while
	function automatic logic [9:0] file_chunk();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return 10'(BLOCK_BYTES);
		if (pick < 90)
			return 10'($urandom_range(0, BLOCK_BYTES - 1));
		return 10'($urandom_range(BLOCK_BYTES + 1, 1023));
	endfunction

	// received data length: mostly full, some short last blocks, a few bad sizes
	function automatic logic [10:0] data_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			return 11'(FULL_PACKET);
		if (pick < 95)
			return 11'($urandom_range(tftpss_pkg::HDR_BYTES, FULL_PACKET - 1));
		if (pick < 97)
			return 11'($urandom_range(0, tftpss_pkg::HDR_BYTES - 1));
		return 11'($urandom_range(FULL_PACKET + 1, 2047));
	endfunction

	// request with the checks mostly passing and a length mostly long enough
	function automatic tftpss_pkg::pkt_t request_pkt(input logic [15:0] op);
		logic [3:0]  checks;
		logic [10:0] len;
		checks = ($urandom_range(0, 99) < 80) ? CHECKS_OK : 4'($urandom);
		len = ($urandom_range(0, 99) < 90)
			? 11'($urandom_range(tftpss_pkg::MIN_REQUEST_BYTES, RECV_BYTES))
			: 11'($urandom);
		return packet(op, 16'($urandom), len, checks, file_chunk());
	endfunction

	// pick the next event from the current session so most traffic follows the protocol
	function automatic tftpss_pkg::pkt_t choose_event();
		int          pick;
		logic [15:0] word;
		pick = $urandom_range(0, 99);
		case (sess_status)
			tftpss_pkg::ST_READ: begin
				if (pick < 72)
					return packet(tftpss_pkg::OP_ACK, sess_block, 11'($urandom),
						4'($urandom), file_chunk());
				if (pick < 80) begin
					// ack for some other block
					word = sess_block + 16'($urandom_range(1, 65535));
					return packet(tftpss_pkg::OP_ACK, word, 11'($urandom), 4'($urandom),
						10'($urandom));
				end
			end
			tftpss_pkg::ST_WRITE: begin
				if (pick < 72) begin
					word = ($urandom_range(0, 99) < 85) ? sess_block + 16'd1
						: sess_block + 16'($urandom_range(1, 1000));
					return packet(tftpss_pkg::OP_DATA, word, data_length(), 4'($urandom),
						10'($urandom));
				end
				if (pick < 80) begin
					// duplicate or old block
					word = 16'($urandom_range(0, sess_block));
					return packet(tftpss_pkg::OP_DATA, word, data_length(), 4'($urandom),
						10'($urandom));
				end
			end
			default: begin
				if (pick < 40)
					return request_pkt(tftpss_pkg::OP_RRQ);
				if (pick < 78)
					return request_pkt(tftpss_pkg::OP_WRQ);
				if (pick < 82)
					return packet(tftpss_pkg::OP_ACK, 16'($urandom), 11'($urandom),
						4'($urandom), 10'($urandom));
				if (pick < 85)
					return packet(tftpss_pkg::OP_DATA, 16'($urandom), data_length(),
						4'($urandom), 10'($urandom));
			end
		endcase
		// common tail: timeouts, requests while busy, peer errors, garbage
		if (pick < 88)
			return timeout_pkt();
		if (pick < 92)
			return request_pkt(pick[0] ? tftpss_pkg::OP_RRQ : tftpss_pkg::OP_WRQ);
		if (pick < 95)
			return packet(tftpss_pkg::OP_ERROR, 16'($urandom), 11'($urandom), 4'($urandom),
				10'($urandom));
		return noise_pkt();
	endfunction

	// ------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------

	// offer one event and wait for its transaction, then book the reply it owes
	task automatic send_event(input tftpss_pkg::pkt_t p);
		int gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		// valid only drops when there really is a gap, so it never toggles within a step
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_ch.valid <= 1'b1;
		pkt_ch.item <= p;
		@(posedge clk);
		while (!pkt_ch.ready)
			@(posedge clk);
		reply_q.push_back(next_reply(p));
		events_sent++;
	endtask

	// stop offering and let every owed reply come back
	task automatic wait_idle();
		pkt_ch.valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic report(input string what, input tftpss_pkg::rsp_t want,
			input tftpss_pkg::rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s (reply %0d)", what, replies_checked);
			$display("  expected act=%0d op=%0d word=%0d len=%0d msg=%0d store=%0d",
				want.action, want.reply_opcode, want.reply_word, want.reply_length,
				want.message_id, want.store_payload);
			$display("  actual   act=%0d op=%0d word=%0d len=%0d msg=%0d store=%0d",
				got.action, got.reply_opcode, got.reply_word, got.reply_length,
				got.message_id, got.store_payload);
		end
	endtask

	// compare one reply transaction with the oldest owed reply
	task automatic check_reply(input tftpss_pkg::rsp_t got);
		tftpss_pkg::rsp_t want;
		replies_checked++;
		if (reply_q.size() == 0) begin
			report("reply with no event pending", '0, got);
			return;
		end
		want = reply_q.pop_front();
		if (got.action !== want.action || got.reply_opcode !== want.reply_opcode
				|| got.reply_word !== want.reply_word
				|| got.reply_length !== want.reply_length
				|| got.message_id !== want.message_id
				|| got.store_payload !== want.store_payload)
			report("reply mismatch", want, got);
	endtask

	// reply side: checks every transaction and stalls at random or on request
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_reply(rsp_ch.item);
				stall = gaps_on ? $urandom_range(0, 7) : 0;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (rsp_hold > 0) begin
				// long hold-off so the block backs up into its input
				rsp_hold--;
				rsp_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: a long run of cycles with no transaction at all means a hang
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pkt_ch.valid && pkt_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles, %0d replies owed",
			QUIET_LIMIT, reply_q.size());
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// bad opcodes, timeout with no session, stray ack and data, peer error
	task automatic test_odd_packets();
		send_event(packet(16'd0, 16'hFFFF, 11'd2047, CHECKS_OK, 10'd1023));
		send_event(packet(16'hFFFF, 16'd0, 11'd0, 4'b0000, 10'd0));
		send_event(packet(16'd6, 16'h5555, 11'h2AA, 4'b1010, 10'h155));
		send_event(timeout_pkt());
		send_event(packet(tftpss_pkg::OP_ACK, 16'd0, 11'd4, CHECKS_OK, 10'd512));
		send_event(packet(tftpss_pkg::OP_DATA, 16'd1, 11'd516, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_ERROR, 16'd3, 11'd20, 4'b0101, 10'd7));
	endtask

	// each request check failing on its own, in priority order
	task automatic test_request_errors();
		send_event(packet(tftpss_pkg::OP_RRQ, 16'd0, 11'd5, CHECKS_OK, 10'd512));
		send_event(packet(tftpss_pkg::OP_WRQ, 16'd0, 11'd0, CHECKS_OK, 10'd512));
		send_event(packet(tftpss_pkg::OP_RRQ, 16'd0, 11'd6, 4'b0111, 10'd512));
		send_event(packet(tftpss_pkg::OP_WRQ, 16'd0, 11'd2047, 4'b1011, 10'd512));
		send_event(packet(tftpss_pkg::OP_RRQ, 16'd0, 11'd100, 4'b1101, 10'd512));
		send_event(packet(tftpss_pkg::OP_RRQ, 16'd0, 11'd100, 4'b1110, 10'd512));
	endtask

	// read transfer: saturated first block, retransmit, busy, stale ack, empty last block
	task automatic test_read_session();
		send_event(packet(tftpss_pkg::OP_RRQ, 16'd0, 11'd1024, CHECKS_OK, 10'd1023));
		send_event(timeout_pkt());
		send_event(packet(tftpss_pkg::OP_WRQ, 16'd0, 11'd20, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_ACK, 16'd0, 11'd4, CHECKS_OK, 10'd512));
		send_event(packet(tftpss_pkg::OP_ACK, 16'd1, 11'd4, CHECKS_OK, 10'd512));
		send_event(packet(tftpss_pkg::OP_ACK, 16'd2, 11'd4, CHECKS_OK, 10'd0));
	endtask

	// write transfer: stale block, full block, busy request, retransmit, size errors at both ends, short last block
	task automatic test_write_session();
		// write requests do not care whether the file exists
		send_event(packet(tftpss_pkg::OP_WRQ, 16'd0, 11'd30, 4'b1100, 10'd0));
		send_event(packet(tftpss_pkg::OP_DATA, 16'd0, 11'd516, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_DATA, 16'd1, 11'd516, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_RRQ, 16'd0, 11'd30, CHECKS_OK, 10'd512));
		send_event(timeout_pkt());
		send_event(packet(tftpss_pkg::OP_DATA, 16'hFFFF, 11'd2047, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_WRQ, 16'd0, 11'd30, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_DATA, 16'd1, 11'd3, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_WRQ, 16'd0, 11'd30, CHECKS_OK, 10'd0));
		send_event(packet(tftpss_pkg::OP_DATA, 16'hFFFF, 11'd4, CHECKS_OK, 10'd0));
	endtask

	// receiver holds off while events keep coming, then the sender drains
	task automatic test_backpressure();
		wait_idle();
		gaps_on = 1'b0;
		rsp_hold = HOLD_CYCLES;
		repeat (30)
			send_event(choose_event());
		wait_idle();
		gaps_on = 1'b1;
	endtask

	// protocol-shaped traffic with noise, idling switched on and off in stretches
	task automatic test_random_traffic(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			// now and then let everything settle before carrying on
			if (i % 250 == 249)
				wait_idle();
			send_event(choose_event());
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.item = '0;
		sess_status = tftpss_pkg::ST_IDLE;
		sess_block = '0;
		sent_hdr = '0;
		gaps_on = 1'b1;
		rsp_hold = 0;
		events_sent = 0;
		replies_checked = 0;
		mismatches = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_odd_packets();
		test_request_errors();
		test_read_session();
		test_write_session();
		test_backpressure();
		test_random_traffic(1190);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d events sent, %0d replies checked, %0d mismatches",
			events_sent, replies_checked, mismatches);
		$display("covered request checks, read and write sessions, back-pressure");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
